[design/egr_pkg.sv]
package egr_pkg;

  localparam int STORE_BYTES = 4096;
  localparam int ADDR_W = $clog2(STORE_BYTES);
  localparam int CNT_W = $clog2(STORE_BYTES + 1);
  localparam int POS_W = 16;
  localparam int OFF_W = POS_W - 3;
  localparam int VAL_W = 33;
  localparam int LIM_W = (CNT_W + 3 > POS_W) ? CNT_W + 3 : POS_W;
  localparam int CMP_W = (CNT_W > OFF_W) ? CNT_W : OFF_W;

  localparam logic [7:0] EPB_BYTE = 8'h03;
  localparam logic [7:0] ZERO_BYTE = 8'h00;

  typedef enum logic [3:0] {
    CMD_CLEAR  = 4'd0,
    CMD_LOAD   = 4'd1,
    CMD_READ   = 4'd2,
    CMD_PEEK   = 4'd3,
    CMD_UE     = 4'd4,
    CMD_SE     = 4'd5,
    CMD_TE     = 4'd6,
    CMD_ME     = 4'd7,
    CMD_SETOFF = 4'd8
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FETCH, ST_BIT, ST_CK_A, ST_CK_B, ST_CK_C, ST_CK_D, ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    PH_FIXED, PH_ZEROS, PH_SUFFIX, PH_TE
  } phase_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  localparam logic [5:0] ME48_A [48] = '{
    6'd0, 6'd16, 6'd1, 6'd2, 6'd4, 6'd8, 6'd32, 6'd3, 6'd5, 6'd10, 6'd12, 6'd15,
    6'd47, 6'd7, 6'd11, 6'd13, 6'd14, 6'd6, 6'd9, 6'd31, 6'd35, 6'd37, 6'd42, 6'd44,
    6'd33, 6'd34, 6'd36, 6'd40, 6'd39, 6'd43, 6'd45, 6'd46, 6'd17, 6'd18, 6'd20, 6'd24,
    6'd19, 6'd21, 6'd26, 6'd28, 6'd23, 6'd27, 6'd29, 6'd30, 6'd22, 6'd25, 6'd38, 6'd41};

  localparam logic [5:0] ME48_B [48] = '{
    6'd47, 6'd31, 6'd15, 6'd0, 6'd23, 6'd27, 6'd29, 6'd30, 6'd7, 6'd11, 6'd13, 6'd14,
    6'd39, 6'd43, 6'd45, 6'd46, 6'd16, 6'd3, 6'd5, 6'd10, 6'd12, 6'd19, 6'd21, 6'd26,
    6'd28, 6'd35, 6'd37, 6'd42, 6'd44, 6'd1, 6'd2, 6'd4, 6'd8, 6'd17, 6'd18, 6'd20,
    6'd24, 6'd6, 6'd9, 6'd22, 6'd25, 6'd32, 6'd33, 6'd34, 6'd36, 6'd40, 6'd38, 6'd41};

  localparam logic [3:0] ME16_A [16] = '{
    4'd15, 4'd0, 4'd7, 4'd11, 4'd13, 4'd14, 4'd3, 4'd5,
    4'd10, 4'd12, 4'd1, 4'd2, 4'd4, 4'd8, 4'd6, 4'd9};

  localparam logic [3:0] ME16_B [16] = '{
    4'd0, 4'd1, 4'd2, 4'd4, 4'd8, 4'd3, 4'd5, 4'd10,
    4'd12, 4'd15, 4'd7, 4'd11, 4'd13, 4'd14, 4'd6, 4'd9};

endpackage

[design/egr_store.sv]
module egr_store (
  input  logic                       clk,
  input  egr_pkg::mem_wr_t           wr,
  input  logic [egr_pkg::ADDR_W-1:0] rd_addr,
  output logic [7:0]                 rd_data_r
);
  import egr_pkg::*;

  // payload bytes, one write and one registered read per cycle
  logic [7:0] mem_r [STORE_BYTES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

endmodule

[design/rbsp_exp_golomb_reader.sv]
// exp-golomb bitstream reader: load a payload byte by byte (up to STORE_BYTES), then issue
// read, peek, ue, se, te and me commands that read it msb first, all but peek advancing the
// pointer; every item returns one result with the value, the sticky error flag and the bit
// position after the item. items are handled one at a time and in_stall is high while one
// is at work. clear, load, set offset and unused codes go straight to the finish state. a
// read fetches the byte, takes one bit per bit state, fetches again each time a byte
// boundary is crossed and, where the boundary byte must be checked for emulation
// prevention, reads up to three bytes one at a time through the single store read port.
// ue/se/te/me read 2*zeros+1 bits (te with v==1 one bit more). the result waits in an
// output register, so the next item is taken while an earlier result is still stalled.
module rbsp_exp_golomb_reader (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [3:0]                       in_command,
  input  logic [7:0]                       in_byte_value,
  input  logic [5:0]                       in_bit_count,
  input  logic [egr_pkg::POS_W-1:0]        in_new_offset,
  input  logic                             in_chroma_present,
  input  logic                             in_me_table_select,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [egr_pkg::VAL_W-1:0] out_value,
  output logic                             out_error,
  output logic [egr_pkg::POS_W-1:0]        out_bit_position
);
  import egr_pkg::*;

  state_t state_r, state_nxt;
  phase_t ph_r, ph_nxt;
  logic [3:0]       cmd_r, cmd_nxt;
  logic             chroma_r, chroma_nxt;
  logic             first_r, first_nxt;
  logic [5:0]       cnt_r, cnt_nxt;         // bits left, or zeros counted
  logic [VAL_W-1:0] acc_r, acc_nxt;         // value+1 for ue codes
  logic [POS_W-1:0] pos_r, pos_nxt;         // working pointer
  logic [POS_W-1:0] ptr_r, ptr_nxt;         // committed pointer
  logic             err_r, err_nxt;         // sticky error
  logic             lerr_r, lerr_nxt;       // error of this item
  logic             skip_r, skip_nxt;       // item returns zero without reading
  logic             fin_r, fin_nxt;         // last bit taken, finish after boundary check
  logic [CNT_W-1:0] loaded_r, loaded_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_value_r, out_value_nxt;
  logic             out_error_r, out_error_nxt;
  logic [POS_W-1:0] out_pos_r, out_pos_nxt;

  mem_wr_t           mem_wr;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data_r;

  egr_store u_store (
    .clk       (clk),
    .wr        (mem_wr),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data_r)
  );

  // combinational helpers
  logic [LIM_W-1:0] limit;
  logic [POS_W-1:0] pos_inc;
  logic [OFF_W-1:0] off_inc, off_cur;
  logic             bit_in, at_bound, need_chk, done_bit;
  logic [VAL_W-1:0] acc_sh, v_dec, mag, res;
  logic [5:0]       sat_cnt, me_idx;
  logic             me_bad, commit, bad, slot_free;
  state_t           after_ck;

  always_comb begin
    limit    = LIM_W'({loaded_r, 3'b000});
    pos_inc  = pos_r + POS_W'(1);
    off_inc  = pos_inc[POS_W-1:3];
    off_cur  = pos_r[POS_W-1:3];
    bit_in   = rd_data_r[3'd7 - pos_r[2:0]];
    at_bound = (pos_inc[2:0] == 3'd0);
    need_chk = at_bound && (CMP_W'(off_inc) < CMP_W'(loaded_r)) && (off_inc > OFF_W'(1));
    acc_sh   = {acc_r[VAL_W-2:0], bit_in};
    sat_cnt  = (in_bit_count > 6'd32) ? 6'd32 : in_bit_count;
    after_ck = fin_r ? ST_FIN : ST_FETCH;
    slot_free = !out_valid_r || !out_stall;

    // finishing values
    v_dec  = acc_r - VAL_W'(1);
    mag    = {1'b0, acc_r[VAL_W-1:1]};
    me_idx = acc_r[5:0] - 6'd1;
    me_bad = (cmd_r == CMD_ME) &&
             (chroma_r ? (acc_r > VAL_W'(48)) : (acc_r > VAL_W'(16)));
    commit = !skip_r && ((cmd_r == CMD_READ) || (cmd_r == CMD_UE) || (cmd_r == CMD_SE) ||
                         (cmd_r == CMD_TE) || (cmd_r == CMD_ME));
    bad    = skip_r || lerr_r || me_bad;
    case (cmd_r)
      CMD_READ, CMD_PEEK: res = acc_r;
      CMD_UE, CMD_TE:     res = v_dec;
      CMD_SE:             res = acc_r[0] ? (VAL_W'(0) - mag) : mag;
      CMD_ME: begin
        if (chroma_r) begin
          res = VAL_W'(first_r ? ME48_A[me_idx] : ME48_B[me_idx]);
        end else begin
          res = VAL_W'(first_r ? ME16_A[me_idx[3:0]] : ME16_B[me_idx[3:0]]);
        end
      end
      default:            res = '0;
    endcase

    state_nxt     = state_r;
    ph_nxt        = ph_r;
    cmd_nxt       = cmd_r;
    chroma_nxt    = chroma_r;
    first_nxt     = first_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    pos_nxt       = pos_r;
    ptr_nxt       = ptr_r;
    err_nxt       = err_r;
    lerr_nxt      = lerr_r;
    skip_nxt      = skip_r;
    fin_nxt       = fin_r;
    loaded_nxt    = loaded_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    out_error_nxt = out_error_r;
    out_pos_nxt   = out_pos_r;
    mem_wr        = '0;
    rd_addr       = off_cur[ADDR_W-1:0];
    in_stall      = (state_r != ST_IDLE);
    done_bit      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_command;
          chroma_nxt = in_chroma_present;
          first_nxt  = in_me_table_select;
          pos_nxt    = ptr_r;
          lerr_nxt   = 1'b0;
          acc_nxt    = '0;
          fin_nxt    = 1'b0;
          skip_nxt   = 1'b1;
          state_nxt  = ST_FIN;
          case (in_command)
            CMD_CLEAR: begin
              loaded_nxt = '0;
              ptr_nxt    = '0;
              err_nxt    = 1'b0;
            end
            CMD_LOAD: begin
              if (loaded_r < CNT_W'(STORE_BYTES)) begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = loaded_r[ADDR_W-1:0];
                mem_wr.data = in_byte_value;
                loaded_nxt  = loaded_r + CNT_W'(1);
              end
            end
            CMD_SETOFF: begin
              if (LIM_W'(in_new_offset) > limit) begin
                err_nxt = 1'b1;
              end else begin
                ptr_nxt = in_new_offset;
              end
            end
            CMD_READ, CMD_PEEK: begin
              skip_nxt = (in_command == CMD_READ) && err_r;
              cnt_nxt  = sat_cnt;
              ph_nxt   = PH_FIXED;
              if (!skip_nxt && sat_cnt != 6'd0) begin
                state_nxt = ST_FETCH;
              end
            end
            CMD_UE, CMD_SE, CMD_TE, CMD_ME: begin
              skip_nxt = err_r;
              cnt_nxt  = '0;
              ph_nxt   = PH_ZEROS;
              if (!err_r) begin
                state_nxt = ST_FETCH;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_FETCH: begin
        state_nxt = ST_BIT;
      end

      ST_BIT: begin
        if (LIM_W'(pos_r) >= limit) begin
          // past the loaded end: pointer stays
          lerr_nxt  = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          pos_nxt = pos_inc;
          case (ph_r)
            PH_FIXED: begin
              acc_nxt  = acc_sh;
              cnt_nxt  = cnt_r - 6'd1;
              done_bit = (cnt_r == 6'd1);
            end
            PH_ZEROS: begin
              if (bit_in) begin
                acc_nxt = VAL_W'(1);
                if (cnt_r == 6'd0) begin
                  done_bit = 1'b1;
                end else begin
                  ph_nxt = PH_SUFFIX;
                end
              end else begin
                cnt_nxt = cnt_r + 6'd1;
                if (cnt_r == 6'd31) begin
                  lerr_nxt = 1'b1;
                  done_bit = 1'b1;
                end
              end
            end
            PH_SUFFIX: begin
              acc_nxt = acc_sh;
              cnt_nxt = cnt_r - 6'd1;
              if (cnt_r == 6'd1) begin
                // te with ue value 1 reads one more bit
                if ((cmd_r == CMD_TE) && (acc_sh == VAL_W'(2))) begin
                  ph_nxt = PH_TE;
                end else begin
                  done_bit = 1'b1;
                end
              end
            end
            default: begin
              // te: acc becomes 2-b so that acc-1 gives 1-b
              acc_nxt  = bit_in ? VAL_W'(1) : VAL_W'(2);
              done_bit = 1'b1;
            end
          endcase
          fin_nxt = done_bit;
          if (need_chk) begin
            state_nxt = ST_CK_A;
          end else if (done_bit) begin
            state_nxt = ST_FIN;
          end else if (at_bound) begin
            state_nxt = ST_FETCH;
          end else begin
            state_nxt = ST_BIT;
          end
        end
      end

      // emulation prevention: byte at off is 0x03 after two 0x00 bytes
      ST_CK_A: begin
        state_nxt = ST_CK_B;
      end

      ST_CK_B: begin
        rd_addr = ADDR_W'(off_cur - OFF_W'(1));
        state_nxt = (rd_data_r == EPB_BYTE) ? ST_CK_C : after_ck;
      end

      ST_CK_C: begin
        rd_addr = ADDR_W'(off_cur - OFF_W'(2));
        state_nxt = (rd_data_r == ZERO_BYTE) ? ST_CK_D : after_ck;
      end

      ST_CK_D: begin
        if (rd_data_r == ZERO_BYTE) begin
          pos_nxt = pos_r + POS_W'(8);
        end
        state_nxt = after_ck;
      end

      ST_FIN: begin
        if (slot_free) begin
          if (commit) begin
            ptr_nxt = pos_r;
            err_nxt = err_r || lerr_r || me_bad;
          end
          out_valid_nxt = 1'b1;
          out_value_nxt = bad ? '0 : res;
          out_error_nxt = commit ? (err_r || lerr_r || me_bad) : err_r;
          out_pos_nxt   = commit ? pos_r : ptr_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      loaded_r    <= '0;
      ptr_r       <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      ptr_r       <= ptr_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ph_r        <= ph_nxt;
    cmd_r       <= cmd_nxt;
    chroma_r    <= chroma_nxt;
    first_r     <= first_nxt;
    cnt_r       <= cnt_nxt;
    acc_r       <= acc_nxt;
    pos_r       <= pos_nxt;
    lerr_r      <= lerr_nxt;
    skip_r      <= skip_nxt;
    fin_r       <= fin_nxt;
    out_value_r <= out_value_nxt;
    out_error_r <= out_error_nxt;
    out_pos_r   <= out_pos_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_value        = out_value_r;
  assign out_error        = out_error_r;
  assign out_bit_position = out_pos_r;

endmodule
